@@ src/nfma_pkg.sv @@
// Shared types, constants and helpers for the narrowing fused multiply-add.
// Used by every module of the block; depends on nothing else.
package nfma_pkg;

  // Alignment window and field widths.
  localparam int WIN_W   = 163;
  localparam int EXT_W   = WIN_W + 56;
  localparam int EXP_W   = 13;
  localparam int PROD_W  = 106;
  localparam int MANT_W  = 53;
  localparam int NORM_W  = 256;
  localparam int KEEP_W  = 26;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [31:0] INF32  = 32'h7F80_0000;
  localparam logic [31:0] MAXF32 = 32'h7F7F_FFFF;
  localparam logic [31:0] NZERO32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RTZ = 2'd1,
    RM_RDN = 2'd2,
    RM_RUP = 2'd3
  } rm_t;

  // A result settled early (NaN, infinity, signed zero).
  typedef struct packed {
    logic        special;
    logic [31:0] res;
  } spec_t;

  // Product and aligned addend, ready for the wide adder.
  typedef struct packed {
    logic [PROD_W-1:0]      mp;
    logic [WIN_W-1:0]       aw;
    logic                   caseb;
    logic                   sub;
    logic                   sp;
    logic                   sc;
    logic signed [EXP_W-1:0] wbase;
    spec_t                  spec;
  } front_t;

  // Magnitude of the exact sum in the window.
  typedef struct packed {
    logic [WIN_W-1:0]       s;
    logic                   rsign;
    logic signed [EXP_W-1:0] wbase;
    spec_t                  spec;
  } sum_t;

  // Normalized top bits with sticky, plus the leading-zero count.
  typedef struct packed {
    logic [KEEP_W-1:0]      v;
    logic [7:0]             lz;
    logic                   zero;
    logic                   rsign;
    logic signed [EXP_W-1:0] wbase;
    spec_t                  spec;
  } norm_t;

  // Overflow goes to infinity or to the largest finite value.
  function automatic logic [31:0] overflow_result(input logic sign, input rm_t mode);
    logic to_max;
    to_max = (mode == RM_RTZ) || (mode == RM_RDN && !sign) || (mode == RM_RUP && sign);
    return {sign, 31'b0} | (to_max ? MAXF32 : INF32);
  endfunction

endpackage

@@ src/nfma_front.sv @@
// Front end: operand unpacking, special cases, four partial products (stage 1),
// product summation and addend alignment (stage 2). Depends on nfma_pkg.
module nfma_front (
  input  logic                  clk,
  input  logic                  en1,
  input  logic                  en2,
  input  nfma_pkg::rm_t         mode,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  input  logic [63:0]           c,
  output nfma_pkg::front_t      fr
);

  logic        sa, sb, sc, sp;
  logic [10:0] ea, eb, ec, eaf, ebf, ecf;
  logic [51:0] fa, fb, fc;
  logic [52:0] ma, mb, mc;
  logic        za, zb, zc, inf_a, inf_b, inf_c, nan_any, pzero;
  logic signed [nfma_pkg::EXP_W-1:0] ea_l, eb_l, ez, ep, d, dsh, wbase;
  logic        caseb, afar;
  logic [7:0]  amt;
  nfma_pkg::spec_t spec;
  logic [51:0] pp_hh_next;
  logic [52:0] pp_hl_next, pp_lh_next;
  logic [53:0] pp_ll_next;

  // Stage 1 registers.
  logic [51:0] pp_hh;
  logic [52:0] pp_hl, pp_lh;
  logic [53:0] pp_ll;
  logic [52:0] mc1;
  logic        afar1, caseb1, sub1, sp1, sc1;
  logic [7:0]  amt1;
  logic signed [nfma_pkg::EXP_W-1:0] wbase1;
  nfma_pkg::spec_t spec1;

  logic [53:0] mid;
  logic [nfma_pkg::PROD_W-1:0] mp;
  logic [nfma_pkg::EXT_W-1:0]  ext;
  logic        ast;

  // Field extraction and classification.
  always_comb begin
    sa = a[63]; sb = b[63]; sc = c[63];
    ea = a[62:52]; eb = b[62:52]; ec = c[62:52];
    fa = a[51:0]; fb = b[51:0]; fc = c[51:0];
    sp = sa ^ sb;
    za = (ea == 11'd0) && (fa == '0);
    zb = (eb == 11'd0) && (fb == '0);
    zc = (ec == 11'd0) && (fc == '0);
    inf_a = (ea == 11'h7FF);
    inf_b = (eb == 11'h7FF);
    inf_c = (ec == 11'h7FF);
    nan_any = (inf_a && fa != '0) || (inf_b && fb != '0) || (inf_c && fc != '0);
    pzero = za || zb;
    ma = {ea != 11'd0, fa};
    mb = {eb != 11'd0, fb};
    mc = {ec != 11'd0, fc};
    eaf = (ea == 11'd0) ? 11'd1 : ea;
    ebf = (eb == 11'd0) ? 11'd1 : eb;
    ecf = (ec == 11'd0) ? 11'd1 : ec;
  end

  // Exponents and addend placement relative to the product.
  always_comb begin
    ea_l = $signed({2'b00, eaf}) - 13'sd1075;
    eb_l = $signed({2'b00, ebf}) - 13'sd1075;
    ez   = $signed({2'b00, ecf}) - 13'sd1075;
    ep   = ea_l + eb_l;
    d    = ez - ep;
    dsh  = d + 13'sd58;
    caseb = pzero || (d > 13'sd108);
    afar  = !caseb && (d < -13'sd58);
    wbase = caseb ? (ez - 13'sd110) : (ep - 13'sd2);
    if (caseb) begin
      amt = 8'd166;
    end else if (afar) begin
      amt = 8'd0;
    end else begin
      amt = dsh[7:0];
    end
  end

  // Results that need no arithmetic.
  always_comb begin
    spec.special = 1'b1;
    spec.res     = nfma_pkg::QNAN32;
    if (nan_any) begin
      spec.res = nfma_pkg::QNAN32;
    end else if (inf_a || inf_b) begin
      if (pzero || (inf_c && sc != sp)) begin
        spec.res = nfma_pkg::QNAN32;
      end else begin
        spec.res = {sp, 31'b0} | nfma_pkg::INF32;
      end
    end else if (inf_c) begin
      spec.res = {sc, 31'b0} | nfma_pkg::INF32;
    end else if (pzero && zc) begin
      spec.res = {(sp == sc) ? sp : (mode == nfma_pkg::RM_RDN), 31'b0};
    end else begin
      spec.special = 1'b0;
    end
  end

  // Four partial products of the 53-bit significands.
  always_comb begin
    pp_hh_next = ma[52:27] * mb[52:27];
    pp_hl_next = ma[52:27] * mb[26:0];
    pp_lh_next = ma[26:0] * mb[52:27];
    pp_ll_next = ma[26:0] * mb[26:0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pp_hh  <= pp_hh_next;
      pp_hl  <= pp_hl_next;
      pp_lh  <= pp_lh_next;
      pp_ll  <= pp_ll_next;
      mc1    <= mc;
      afar1  <= afar;
      caseb1 <= caseb;
      sub1   <= sp ^ sc;
      sp1    <= sp;
      sc1    <= sc;
      amt1   <= amt;
      wbase1 <= wbase;
      spec1  <= spec;
    end
  end

  // Stage 2: sum the partial products and shift the addend into the window.
  always_comb begin
    mid = {1'b0, pp_hl} + {1'b0, pp_lh};
    mp  = {pp_hh, 54'b0} + {25'b0, mid, 27'b0} + {52'b0, pp_ll};
    ext = {{(nfma_pkg::EXT_W - nfma_pkg::MANT_W){1'b0}}, mc1} << amt1;
    ast = afar1 ? (mc1 != '0) : (|ext[55:0]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      fr.mp    <= mp;
      fr.aw    <= ext[nfma_pkg::EXT_W-1:56] | {{(nfma_pkg::WIN_W-1){1'b0}}, ast};
      fr.caseb <= caseb1;
      fr.sub   <= sub1;
      fr.sp    <= sp1;
      fr.sc    <= sc1;
      fr.wbase <= wbase1;
      fr.spec  <= spec1;
    end
  end

endmodule

@@ src/nfma_add.sv @@
// Wide add/subtract of the placed product and addend (stage 3).
// Depends on nfma_pkg.
module nfma_add (
  input  logic             clk,
  input  logic             en3,
  input  nfma_pkg::front_t fr,
  output nfma_pkg::sum_t   sm
);

  logic [nfma_pkg::WIN_W-1:0] pw;
  logic [nfma_pkg::WIN_W:0]   sum, d1, d2;
  logic [nfma_pkg::WIN_W-1:0] s;
  logic                       rsign;

  // Product goes into the window, or collapses to a sticky unit when far below.
  always_comb begin
    if (fr.caseb) begin
      pw = {{(nfma_pkg::WIN_W-1){1'b0}}, fr.mp != '0};
    end else begin
      pw = {55'b0, fr.mp, 2'b0};
    end
    sum = {1'b0, pw} + {1'b0, fr.aw};
    d1  = {1'b0, pw} - {1'b0, fr.aw};
    d2  = {1'b0, fr.aw} - {1'b0, pw};
  end

  // Pick the magnitude and the sign of the exact sum.
  always_comb begin
    if (!fr.sub) begin
      s = sum[nfma_pkg::WIN_W-1:0];
      rsign = fr.sp;
    end else if (!d1[nfma_pkg::WIN_W]) begin
      s = d1[nfma_pkg::WIN_W-1:0];
      rsign = fr.sp;
    end else begin
      s = d2[nfma_pkg::WIN_W-1:0];
      rsign = fr.sc;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sm.s     <= s;
      sm.rsign <= rsign;
      sm.wbase <= fr.wbase;
      sm.spec  <= fr.spec;
    end
  end

endmodule

@@ src/nfma_norm.sv @@
// Leading-zero normalization in two stages (coarse shifts, then fine shifts).
// Depends on nfma_pkg.
module nfma_norm (
  input  logic            clk,
  input  logic            en4,
  input  logic            en5,
  input  nfma_pkg::sum_t  sm,
  output nfma_pkg::norm_t nm
);

  logic [nfma_pkg::NORM_W-1:0] xa, xb;
  logic [3:0] ca, cb;

  // Stage 4 registers.
  logic [nfma_pkg::NORM_W-1:0] x4;
  logic [3:0] c4;
  logic       rsign4;
  logic signed [nfma_pkg::EXP_W-1:0] wbase4;
  nfma_pkg::spec_t spec4;

  // Coarse steps: shift by 128, 64, 32 and 16 where the top is empty.
  always_comb begin
    xa = {sm.s, {(nfma_pkg::NORM_W - nfma_pkg::WIN_W){1'b0}}};
    ca = 4'b0;
    if (xa[255:128] == '0) begin
      xa = xa << 128; ca[3] = 1'b1;
    end
    if (xa[255:192] == '0) begin
      xa = xa << 64; ca[2] = 1'b1;
    end
    if (xa[255:224] == '0) begin
      xa = xa << 32; ca[1] = 1'b1;
    end
    if (xa[255:240] == '0) begin
      xa = xa << 16; ca[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      x4     <= xa;
      c4     <= ca;
      rsign4 <= sm.rsign;
      wbase4 <= sm.wbase;
      spec4  <= sm.spec;
    end
  end

  // Fine steps: shift by 8, 4, 2 and 1.
  always_comb begin
    xb = x4;
    cb = 4'b0;
    if (xb[255:248] == '0) begin
      xb = xb << 8; cb[3] = 1'b1;
    end
    if (xb[255:252] == '0) begin
      xb = xb << 4; cb[2] = 1'b1;
    end
    if (xb[255:254] == '0) begin
      xb = xb << 2; cb[1] = 1'b1;
    end
    if (!xb[255]) begin
      xb = xb << 1; cb[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      nm.v     <= {xb[255:231], |xb[230:0]};
      nm.lz    <= {c4, cb};
      nm.zero  <= !xb[255];
      nm.rsign <= rsign4;
      nm.wbase <= wbase4;
      nm.spec  <= spec4;
    end
  end

endmodule

@@ src/nfma_round.sv @@
// Exponent, subnormal shift (stage 6), rounding and packing (stage 7).
// Depends on nfma_pkg.
module nfma_round (
  input  logic            clk,
  input  logic            en6,
  input  logic            en7,
  input  nfma_pkg::rm_t   mode,
  input  nfma_pkg::norm_t nm,
  output logic [31:0]     res
);

  logic signed [nfma_pkg::EXP_W-1:0] e, rr, ebias;
  logic        normal;
  logic [4:0]  rcap;
  logic [nfma_pkg::KEEP_W-1:0] shifted, lostmask;

  // Stage 6 registers.
  logic [23:0] m;
  logic        rb, st, normal6, ovf6, rsign6, zero6;
  logic [7:0]  eb8;
  nfma_pkg::spec_t spec6;

  logic        inc;
  logic [24:0] m25;
  logic [31:0] nbits, res_next;
  logic        ovf;

  // Result exponent and the right shift into the subnormal range.
  always_comb begin
    e = 13'sd162 - $signed({5'b0, nm.lz}) + nm.wbase;
    ebias = e + 13'sd126;
    rr = -13'sd126 - e;
    normal = (e >= -13'sd126);
    if (normal) begin
      rcap = 5'd0;
    end else if (rr > 13'sd26) begin
      rcap = 5'd26;
    end else begin
      rcap = rr[4:0];
    end
    shifted  = nm.v >> rcap;
    lostmask = ~({nfma_pkg::KEEP_W{1'b1}} << rcap);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      m       <= shifted[25:2];
      rb      <= shifted[1];
      st      <= shifted[0] | (|(nm.v & lostmask));
      normal6 <= normal;
      ovf6    <= (e > 13'sd127);
      eb8     <= ebias[7:0];
      rsign6  <= nm.rsign;
      zero6   <= nm.zero;
      spec6   <= nm.spec;
    end
  end

  // Rounding increment by mode.
  always_comb begin
    unique case (mode)
      nfma_pkg::RM_RNE: inc = rb && (st || m[0]);
      nfma_pkg::RM_RTZ: inc = 1'b0;
      nfma_pkg::RM_RDN: inc = (rb || st) && rsign6;
      nfma_pkg::RM_RUP: inc = (rb || st) && !rsign6;
    endcase
  end

  // Pack, with overflow and the special cases taking priority.
  always_comb begin
    m25   = {1'b0, m} + {24'b0, inc};
    nbits = {1'b0, eb8, 23'b0} + {7'b0, m25};
    ovf   = ovf6 || (normal6 && (nbits >= nfma_pkg::INF32));
    if (spec6.special) begin
      res_next = spec6.res;
    end else if (zero6) begin
      res_next = (mode == nfma_pkg::RM_RDN) ? nfma_pkg::NZERO32 : 32'b0;
    end else if (ovf) begin
      res_next = nfma_pkg::overflow_result(rsign6, mode);
    end else if (normal6) begin
      res_next = {rsign6, nbits[30:0]};
    end else begin
      res_next = {rsign6, 6'b0, m25};
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      res <= res_next;
    end
  end

endmodule

@@ src/narrowing_fused_multiply_add.sv @@
// Narrowing fused multiply-add: three binary64 operands in, one binary32 out.
// Depends on nfma_pkg, nfma_front, nfma_add, nfma_norm and nfma_round.
//
// Usage: present mult_a_bits, mult_b_bits and addend_bits with in_valid; the
// operation transfers on a clock edge where in_valid is high and in_stall is
// low. The result sum_bits = a*b+addend, rounded once to binary32 in the mode
// held by the rounding-mode register, transfers when out_valid is high and
// out_stall is low. The register is written by cfg_write with cfg_data and
// should be changed only while no operation is in flight.
// There are 7 register stages, and out_valid rises when an operation reaches
// the last of them. The pipeline takes a new operation every cycle unless
// in_stall is high. Stages: partial products, product sum and addend alignment,
// wide add, two normalize stages, subnormal shift, round and pack.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps filling into empty stages; in_stall rises only once every
// stage holds an operation. Reset clears all valid bits and sets the mode to
// round-to-nearest-even.
module narrowing_fused_multiply_add (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] mult_a_bits,
  input  logic [63:0] mult_b_bits,
  input  logic [63:0] addend_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sum_bits
);

  nfma_pkg::rm_t    mode;
  logic [7:1]       v, v_next, adv;
  nfma_pkg::front_t fr;
  nfma_pkg::sum_t   sm;
  nfma_pkg::norm_t  nm;

  // Rounding-mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= nfma_pkg::RM_RNE;
    end else if (cfg_write) begin
      mode <= nfma_pkg::rm_t'(cfg_data);
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[7] = !v[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
    v_next[1] = adv[1] ? in_valid : v[1];
    for (int k = 2; k <= 7; k++) begin
      v_next[k] = adv[k] ? v[k-1] : v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = v[7];

  nfma_front u_front (
    .clk  (clk),
    .en1  (adv[1]),
    .en2  (adv[2]),
    .mode (mode),
    .a    (mult_a_bits),
    .b    (mult_b_bits),
    .c    (addend_bits),
    .fr   (fr)
  );

  nfma_add u_add (
    .clk (clk),
    .en3 (adv[3]),
    .fr  (fr),
    .sm  (sm)
  );

  nfma_norm u_norm (
    .clk (clk),
    .en4 (adv[4]),
    .en5 (adv[5]),
    .sm  (sm),
    .nm  (nm)
  );

  nfma_round u_round (
    .clk  (clk),
    .en6  (adv[6]),
    .en7  (adv[7]),
    .mode (mode),
    .nm   (nm),
    .res  (sum_bits)
  );

  // An empty output register means the pipeline can always take a transfer.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // Any all-ones exponent on the output is an infinity or the canonical NaN.
  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sum_bits[30:23] == 8'hFF) |->
      (sum_bits[22:0] == 23'b0 || sum_bits == nfma_pkg::QNAN32))
    else $error("non-canonical NaN on the output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
